[rtl/aip_pkg.sv]
// aip_pkg: shared types, widths and character codes for the ASCII integer parser.
// No dependencies; imported by the interfaces, the top level and the checker.
package aip_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int OUT_BITS       = 32;
  localparam int CH_BITS        = 8;
  localparam int RADIX_BITS     = 5;
  localparam int DIGIT_BITS     = 6;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_PREFIX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_A_UP  = 8'h41;
  localparam logic [CH_BITS-1:0] CH_B_UP  = 8'h42;
  localparam logic [CH_BITS-1:0] CH_X_UP  = 8'h58;
  localparam logic [CH_BITS-1:0] CH_Z_UP  = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_A_LO  = 8'h61;
  localparam logic [CH_BITS-1:0] CH_B_LO  = 8'h62;
  localparam logic [CH_BITS-1:0] CH_X_LO  = 8'h78;
  localparam logic [CH_BITS-1:0] CH_Z_LO  = 8'h7A;

  localparam logic [RADIX_BITS-1:0] RADIX_BIN = 5'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT = 5'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC = 5'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX = 5'd16;

  localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 6'd36;

  // 0..35 for 0-9, a-z, A-Z; DIGIT_NONE otherwise
  function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
    logic [CH_BITS-1:0] d;
    begin
      d = CH_BITS'(DIGIT_NONE);
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c - CH_ZERO;
      end else if (c >= CH_A_LO && c <= CH_Z_LO) begin
        d = c - CH_A_LO + 8'd10;
      end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
        d = c - CH_A_UP + 8'd10;
      end
      return DIGIT_BITS'(d);
    end
  endfunction

endpackage

[rtl/aip_if.sv]
// aip_if: valid/ready channel interfaces for the parser's character input and result output.
// Depends on aip_pkg for field widths.
interface aip_in_if;
  import aip_pkg::*;
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] ch;
  logic               last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface aip_out_if;
  import aip_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/ascii_integer_parser_top.sv]
// ascii_integer_parser_top: streaming ASCII-to-integer parser, one character per word.
// Takes 1 word/cycle unless a last word waits for a stalled result register to drain.
// Input register -> parse step (shift-add by radix) -> result register; negation at the output.
// Reset (rst, synchronous) clears both registers' valid and returns the parser to leading state.
// Depends on aip_pkg and aip_if.
module ascii_integer_parser_top #(
  parameter int VALUE_BITS = aip_pkg::VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  aip_in_if.sink    chars,
  aip_out_if.source result
);
  import aip_pkg::*;

  logic                    s1_valid;
  logic [CH_BITS-1:0]      s1_ch;
  logic                    s1_last;
  logic                    s1_go;
  logic                    in_acc;

  phase_t                  phase, phase_next;
  logic                    negative, negative_next;
  logic [RADIX_BITS-1:0]   radix, radix_next;
  logic [VALUE_BITS-1:0]   acc, acc_next;

  logic [DIGIT_BITS-1:0]   digit;
  logic                    take;
  logic [VALUE_BITS-1:0]   scaled;

  logic                    out_valid;
  logic                    out_neg;
  logic [VALUE_BITS-1:0]   out_acc;
  logic signed [VALUE_BITS-1:0] signed_val;

  assign s1_go       = s1_valid && (!s1_last || !out_valid || result.ready);
  assign chars.ready = !s1_valid || s1_go;
  assign in_acc      = chars.valid && chars.ready;
  assign digit       = digit_of(s1_ch);

  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    radix_next    = radix;
    take          = 1'b0;
    unique case (phase)
      PH_LEAD: begin
        if (s1_ch == CH_SPACE || s1_ch == CH_TAB) begin
          phase_next = PH_LEAD;
        end else if (s1_ch == CH_MINUS) begin
          negative_next = !negative;
          phase_next    = PH_SIGN;
        end else if (s1_ch == CH_ZERO) begin
          phase_next = PH_PREFIX;
        end else begin
          phase_next = PH_DIGITS;
          take       = 1'b1;
        end
      end
      PH_SIGN: begin
        if (s1_ch == CH_MINUS) begin
          negative_next = !negative;
        end else if (s1_ch == CH_ZERO) begin
          phase_next = PH_PREFIX;
        end else begin
          phase_next = PH_DIGITS;
          take       = 1'b1;
        end
      end
      PH_PREFIX: begin
        phase_next = PH_DIGITS;
        if (s1_ch == CH_X_LO || s1_ch == CH_X_UP) begin
          radix_next = RADIX_HEX;
        end else if (s1_ch == CH_B_LO || s1_ch == CH_B_UP) begin
          radix_next = RADIX_BIN;
        end else begin
          radix_next = RADIX_OCT;
          take       = 1'b1;
        end
      end
      PH_DIGITS: take = 1'b1;
      default:   phase_next = PH_DONE;
    endcase
    if (take && digit >= {1'b0, radix_next}) begin
      phase_next = PH_DONE;
    end
  end

  always_comb begin
    unique case (radix_next)
      RADIX_BIN: scaled = acc << 1;
      RADIX_OCT: scaled = acc << 3;
      RADIX_HEX: scaled = acc << 4;
      default:   scaled = (acc << 3) + (acc << 1);
    endcase
    if (take && digit < {1'b0, radix_next}) begin
      acc_next = scaled + VALUE_BITS'(digit);
    end else begin
      acc_next = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_LEAD;
      negative  <= 1'b0;
      radix     <= RADIX_DEC;
      acc       <= '0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last) begin
          phase    <= PH_LEAD;
          negative <= 1'b0;
          radix    <= RADIX_DEC;
          acc      <= '0;
        end else begin
          phase    <= phase_next;
          negative <= negative_next;
          radix    <= radix_next;
          acc      <= acc_next;
        end
      end
      if (s1_go && s1_last) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch   <= chars.ch;
      s1_last <= chars.last;
    end
    if (s1_go && s1_last) begin
      out_acc <= acc_next;
      out_neg <= negative_next;
    end
  end

  assign signed_val   = out_neg ? -out_acc : out_acc;
  assign result.valid = out_valid;
  assign result.value = OUT_BITS'(signed_val);

endmodule

[rtl/aip_checker.sv]
// aip_checker: port-level assertions for ascii_integer_parser_top, attached by bind.
// Tracks words with last accepted against result words delivered.
module aip_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_last,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [aip_pkg::OUT_BITS-1:0] out_value
);
  import aip_pkg::*;

  logic [2:0] pending;
  logic       in_end;
  logic       out_acc;

  assign in_end  = in_valid && in_ready && in_last;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'b0, in_end} - {2'b0, out_acc};
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 3'd0)
    else $error("result word with no string end pending");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more than two results pending");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("stalled result word changed");

endmodule

bind ascii_integer_parser_top aip_checker u_aip_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (chars.valid),
  .in_ready  (chars.ready),
  .in_last   (chars.last),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_value (result.value)
);

[bench/ascii_integer_parser_top_tb.sv]
// ascii_integer_parser_top_tb: self-checking bench for the streaming ASCII integer parser.
// Drives strings of character words with random gaps and back-pressure, predicts each value.
// Depends on rtl/aip_pkg.sv, rtl/aip_if.sv and rtl/ascii_integer_parser_top.sv.
module ascii_integer_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aip_pkg::*;

  localparam int CHAR_TARGET = 1725;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [CH_BITS-1:0] ch;
    logic               last;
  } char_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aip_in_if  chars_if ();
  aip_out_if result_if ();

  ascii_integer_parser_top dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if),
    .result(result_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  char_word_t                 char_backlog[$];
  logic signed [OUT_BITS-1:0] expected_values[$];
  int                         errors = 0;
  int                         cycles = 0;

  // parser state mirror
  phase_t                 ps_phase;
  logic                   ps_negative;
  logic [RADIX_BITS-1:0]  ps_radix;
  logic [OUT_BITS-1:0]    ps_acc;

  function automatic int char_digit(input logic [CH_BITS-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_A_LO && c <= CH_Z_LO) return int'(c - CH_A_LO) + 10;
    if (c >= CH_A_UP && c <= CH_Z_UP) return int'(c - CH_A_UP) + 10;
    return 36;
  endfunction

  function automatic logic [CH_BITS-1:0] digit_char(input int d, input bit upper);
    if (d < 10) return CH_ZERO + CH_BITS'(d);
    return (upper ? CH_A_UP : CH_A_LO) + CH_BITS'(d - 10);
  endfunction

  function automatic void clear_parser();
    ps_phase    = PH_LEAD;
    ps_negative = 1'b0;
    ps_radix    = RADIX_DEC;
    ps_acc      = '0;
  endfunction

  function automatic void accumulate(input logic [CH_BITS-1:0] c);
    int d;
    d = char_digit(c);
    if (d < int'(ps_radix)) ps_acc = ps_acc * OUT_BITS'(ps_radix) + OUT_BITS'(d);
    else ps_phase = PH_DONE;
  endfunction

  function automatic void open_number(input logic [CH_BITS-1:0] c);
    if (c == CH_ZERO) begin
      ps_phase = PH_PREFIX;
    end else begin
      ps_phase = PH_DIGITS;
      accumulate(c);
    end
  endfunction

  function automatic void parse_char(input logic [CH_BITS-1:0] c, input logic lst);
    case (ps_phase)
      PH_LEAD: begin
        if (c == CH_MINUS) begin
          ps_negative = ~ps_negative;
          ps_phase    = PH_SIGN;
        end else if (c != CH_SPACE && c != CH_TAB) begin
          open_number(c);
        end
      end
      PH_SIGN: begin
        if (c == CH_MINUS) ps_negative = ~ps_negative;
        else open_number(c);
      end
      PH_PREFIX: begin
        ps_phase = PH_DIGITS;
        if (c == CH_X_LO || c == CH_X_UP) begin
          ps_radix = RADIX_HEX;
        end else if (c == CH_B_LO || c == CH_B_UP) begin
          ps_radix = RADIX_BIN;
        end else begin
          ps_radix = RADIX_OCT;
          accumulate(c);
        end
      end
      PH_DIGITS: accumulate(c);
      default: ps_phase = PH_DONE;
    endcase
    if (lst) begin
      expected_values.push_back(ps_negative ? -ps_acc : ps_acc);
      clear_parser();
    end
  endfunction

  // mostly short gaps, a few long ones, and occasional runs with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_char(input logic [CH_BITS-1:0] c, input logic lst);
    char_word_t w;
    w.ch   = c;
    w.last = lst;
    char_backlog.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  task automatic push_number();
    int  base;
    int  kind;
    int  ndig;
    bit  upper;
    base  = 10;
    kind  = $urandom_range(0, 9);
    upper = 1'($urandom_range(0, 1));
    repeat ($urandom_range(0, 2)) push_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_char(CH_MINUS, 1'b0);
    if (kind >= 4) begin
      push_char(CH_ZERO, 1'b0);
      if (kind < 6) begin
        base = 8;
      end else if (kind < 8) begin
        base = 16;
        push_char(upper ? CH_X_UP : CH_X_LO, 1'b0);
      end else begin
        base = 2;
        push_char(upper ? CH_B_UP : CH_B_LO, 1'b0);
      end
    end
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(7, base == 2 ? 36 : 14)
                                       : $urandom_range(1, 6);
    for (int i = 0; i < ndig; i++) begin
      if (base == 10 && i == 0) push_char(digit_char($urandom_range(1, 9), 1'b0), 1'b0);
      else push_char(digit_char($urandom_range(0, base - 1), 1'($urandom_range(0, 1))), 1'b0);
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_char(CH_BITS'($urandom_range(0, 255)), 1'b0);
    char_backlog[char_backlog.size() - 1].last = 1'b1;
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 4)) push_char(CH_BITS'($urandom_range(0, 255)), 1'b0);
    char_backlog[char_backlog.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [OUT_BITS-1:0] got,
                                 input logic [OUT_BITS-1:0] want);
    $display("mismatch at cycle %0d: %s: got %h expected %h", cycles, what, got, want);
    errors++;
  endtask

  // character driver
  char_word_t next_word;
  int         src_gap  = 0;
  int         src_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) parse_char(chars_if.ch, chars_if.last);
      if (!chars_if.valid || chars_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          chars_if.valid <= 1'b0;
        end else if (char_backlog.size() > 0) begin
          next_word      = char_backlog.pop_front();
          chars_if.valid <= 1'b1;
          chars_if.ch    <= next_word.ch;
          chars_if.last  <= next_word.last;
          src_gap        = pick_gap(src_calm);
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  // result back-pressure
  int sink_stall = 0;
  int sink_calm  = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
      sink_stall = pick_gap(sink_calm);
    end
  end

  // result monitor
  logic signed [OUT_BITS-1:0] want_value;

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_values.size() == 0) begin
        report_mismatch("result word with nothing pending", result_if.value, '0);
      end else begin
        want_value = expected_values.pop_front();
        if (result_if.value !== want_value) report_mismatch("value", result_if.value, want_value);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ascii_integer_parser_top regression: fail");
      $finish;
    end
  end

  initial begin
    chars_if.valid  = 1'b0;
    chars_if.ch     = '0;
    chars_if.last   = 1'b0;
    result_if.ready = 1'b0;
    clear_parser();

    push_char(8'h00, 1'b1);
    push_text(" \t-7");
    push_text("--9");
    push_text("0x");
    push_text("0B1");
    push_text("08");
    push_text("- 5");
    push_text("0XaF");
    push_char(8'hFF, 1'b1);
    push_text("9z");
    while (char_backlog.size() < CHAR_TARGET) begin
      if ($urandom_range(0, 99) < 15) push_noise();
      else push_number();
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (char_backlog.size() > 0 || chars_if.valid) @(posedge clk);
    while (expected_values.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("ascii_integer_parser_top regression: pass");
    end else begin
      $display("ascii_integer_parser_top regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/aip_pkg.sv
rtl/aip_if.sv
rtl/ascii_integer_parser_top.sv
rtl/aip_checker.sv
bench/ascii_integer_parser_top_tb.sv
